>>> src/two_way_sorted_run_merge_defines.svh
// Assertion macros for the two-way sorted run merge.
`ifndef TWO_WAY_SORTED_RUN_MERGE_DEFINES_SVH
`define TWO_WAY_SORTED_RUN_MERGE_DEFINES_SVH
// Clocked assertion with an active-low asynchronous reset that disables it.
`define TSRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define TSRM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> src/tsrm_pkg.sv
// Package with the shared constants and the float ordering function of the run merge.
package tsrm_pkg;
    localparam int DEFAULT_RUN_DEPTH = 32;
    localparam int OP_W = 2;
    localparam int VAL_W = 32;
    localparam logic [OP_W-1:0] OP_LEFT = 2'd0;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd2;

    // IEEE less-than: false on any NaN, and the two zeros compare equal.
    function automatic logic f32_less(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic [VAL_W-1:0] ka;
        logic [VAL_W-1:0] kb;
        a_nan = (a[30:0] > 31'h7F800000);
        b_nan = (b[30:0] > 31'h7F800000);
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        if (a_nan || b_nan)
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b0;
        return ka < kb;
    endfunction
endpackage

>>> src/tsrm_store.sv
// One run store: appends at the tail, registered read at a chosen index.
module tsrm_store #(
    parameter int RUN_DEPTH = tsrm_pkg::DEFAULT_RUN_DEPTH,
    parameter int IDX_W = $clog2(RUN_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [tsrm_pkg::VAL_W-1:0]   wr_data,
    input  logic [IDX_W-1:0]             rd_idx,
    output logic [tsrm_pkg::VAL_W-1:0]   rd_data
);
    import tsrm_pkg::*;
    localparam int A_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    logic [VAL_W-1:0] mem [RUN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[A_W-1:0]] <= wr_data;
        rd_data <= mem[rd_idx[A_W-1:0]];
    end
endmodule

>>> src/two_way_sorted_run_merge.sv
// Top level of the two-way merge of sorted single-precision runs.
// Appends do not leave the idle state; the block is ready again on the next cycle.
// During a merge each element passes through a memory read state, a compare state and an
// output state that holds while m_tready is low; ready returns after the last element is taken.
// A merge of two empty runs stays idle and gives no result.
// Reset (rst_n, asynchronous, active low) empties both runs and clears the overflow flag that feeds dropped.
module two_way_sorted_run_merge #(
    parameter int RUN_DEPTH = tsrm_pkg::DEFAULT_RUN_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], zero [39:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value_res [31:0]
    output logic [1:0]  m_tuser,   // from_right [0], dropped [1]
    output logic        m_tlast    // last
);
    import tsrm_pkg::*;
    `include "two_way_sorted_run_merge_defines.svh"

    localparam int IDX_W = $clog2(RUN_DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(RUN_DEPTH);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [IDX_W-1:0] lcnt_reg, lcnt_next, rcnt_reg, rcnt_next;
    logic [IDX_W-1:0] li_reg, li_next, ri_reg, ri_next;
    logic drop_reg, drop_next;
    logic ov_reg, ov_next;
    logic [31:0] val_reg, val_next;
    logic fr_reg, fr_next, last_reg, last_next;
    logic [IDX_W-1:0] l_rd_idx, r_rd_idx;
    logic [31:0] l_data, r_data;
    logic s_fire, l_wr, r_wr;
    logic [1:0] op;
    logic l_left, r_left, take_left;

    assign op = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign l_wr = s_fire && op == OP_LEFT && lcnt_reg < DEPTH_C;
    assign r_wr = s_fire && op == OP_RIGHT && rcnt_reg < DEPTH_C;
    assign l_rd_idx = li_reg;
    assign r_rd_idx = ri_reg;

    tsrm_store #(.RUN_DEPTH(RUN_DEPTH), .IDX_W(IDX_W)) u_left (
        .clk(clk), .wr_en(l_wr), .wr_idx(lcnt_reg), .wr_data(s_tdata[31:0]),
        .rd_idx(l_rd_idx), .rd_data(l_data));
    tsrm_store #(.RUN_DEPTH(RUN_DEPTH), .IDX_W(IDX_W)) u_right (
        .clk(clk), .wr_en(r_wr), .wr_idx(rcnt_reg), .wr_data(s_tdata[31:0]),
        .rd_idx(r_rd_idx), .rd_data(r_data));

    // Heads still pending in each run, and the shared comparator decision.
    assign l_left = li_reg < lcnt_reg;
    assign r_left = ri_reg < rcnt_reg;
    always_comb
    begin
        if (l_left && r_left)
            take_left = f32_less(l_data, r_data);
        else
            take_left = l_left;
    end

    always_comb
    begin
        state_next = state_reg;
        lcnt_next = lcnt_reg;
        rcnt_next = rcnt_reg;
        li_next = li_reg;
        ri_next = ri_reg;
        drop_next = drop_reg;
        ov_next = ov_reg;
        val_next = val_reg;
        fr_next = fr_reg;
        last_next = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (op)
                        OP_LEFT:
                        begin
                            if (l_wr)
                                lcnt_next = lcnt_reg + 1'b1;
                            else
                                ov_next = 1'b1;
                        end
                        OP_RIGHT:
                        begin
                            if (r_wr)
                                rcnt_next = rcnt_reg + 1'b1;
                            else
                                ov_next = 1'b1;
                        end
                        OP_MERGE:
                        begin
                            drop_next = ov_reg;
                            ov_next = 1'b0;
                            li_next = '0;
                            ri_next = '0;
                            if (lcnt_reg != '0 || rcnt_reg != '0)
                                state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
                state_next = ST_PICK;
            ST_PICK:
            begin
                // Memory read data for the current heads is valid here.
                if (take_left)
                begin
                    val_next = l_data;
                    li_next = li_reg + 1'b1;
                end
                else
                begin
                    val_next = r_data;
                    ri_next = ri_reg + 1'b1;
                end
                fr_next = !take_left;
                last_next = (take_left ? (li_reg + 1'b1 == lcnt_reg) && !r_left
                                       : (ri_reg + 1'b1 == rcnt_reg) && !l_left);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        // Both runs are emptied, so the read indexes go back to the start.
                        lcnt_next = '0;
                        rcnt_next = '0;
                        li_next = '0;
                        ri_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            li_reg <= '0;
            ri_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lcnt_reg <= lcnt_next;
            rcnt_reg <= rcnt_next;
            li_reg <= li_next;
            ri_reg <= ri_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
        val_reg <= val_next;
        fr_reg <= fr_next;
        last_reg <= last_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = val_reg;
    assign m_tuser = {drop_reg, fr_reg};
    assign m_tlast = last_reg;

    `TSRM_ASSERT(a_cnt_bound, (lcnt_reg <= DEPTH_C && rcnt_reg <= DEPTH_C), "run count above depth")
    `TSRM_ASSERT(a_idx_bound, (li_reg <= lcnt_reg && ri_reg <= rcnt_reg), "merge index past run")
    `TSRM_ASSERT(a_last_empties, (m_tvalid && m_tready && m_tlast |=> lcnt_reg == '0 && rcnt_reg == '0), "runs not emptied after merge")
    `TSRM_ASSERT(a_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "result changed while stalled")
endmodule

>>> tb/tb_two_way_sorted_run_merge.sv
// Self-checking testbench for the two-way merge of sorted single-precision runs.
`timescale 1ns / 100ps

module tb_two_way_sorted_run_merge;
    import tsrm_pkg::*;

    localparam int DEPTH = DEFAULT_RUN_DEPTH;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [31:0] value;
        logic        from_right;
        logic        last;
        logic        dropped;
    } merged_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // value [31:0], zero [39:32]
    logic [1:0]  s_tuser;    // op [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // value_res [31:0]
    logic [1:0]  m_tuser;    // from_right [0], dropped [1]
    logic        m_tlast;

    two_way_sorted_run_merge u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Commands waiting to be offered, and the merged elements still owed by the block.
    cmd_t    pending_cmds[$];
    merged_t owed_elems[$];

    // Shadow copy of the two runs and the sticky overflow flag.
    logic [31:0] left_run[DEPTH];
    logic [31:0] right_run[DEPTH];
    int          left_fill;
    int          right_fill;
    logic        overflow_flag;

    int  errors;
    int  merges_seen;
    int  elems_seen;
    int  cycles;
    int  hold_off;        // long receiver stall requested by the stimulus
    int  src_gap;
    int  snk_gap;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // IEEE less-than on bit patterns: any NaN gives false, and the two zeros are equal.
    function automatic bit float_below(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        if (a[30:0] > 31'h7F800000 || b[30:0] > 31'h7F800000)
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b0;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        return ka < kb;
    endfunction

    // Applies one accepted command to the shadow state and queues the elements it yields.
    task automatic predict_merge(cmd_t c);
        int      li;
        int      ri;
        bit      take_l;
        merged_t e;
        li = 0;
        ri = 0;
        case (c.op)
            OP_LEFT:
                if (left_fill < DEPTH) left_run[left_fill++] = c.value;
                else overflow_flag = 1'b1;
            OP_RIGHT:
                if (right_fill < DEPTH) right_run[right_fill++] = c.value;
                else overflow_flag = 1'b1;
            OP_MERGE:
            begin
                while (li + ri < left_fill + right_fill)
                begin
                    if (li < left_fill && ri < right_fill)
                        take_l = float_below(left_run[li], right_run[ri]);
                    else
                        take_l = (li < left_fill);
                    e.value = take_l ? left_run[li] : right_run[ri];
                    if (take_l) li++;
                    else ri++;
                    e.from_right = !take_l;
                    e.last = (li + ri == left_fill + right_fill);
                    e.dropped = overflow_flag;
                    owed_elems.push_back(e);
                end
                left_fill = 0;
                right_fill = 0;
                overflow_flag = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A random float pattern, biased towards the interesting classes.
    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = {v[31], 31'd0};                           // signed zero
            1: v = {v[31], 8'hFF, 23'd0};                    // infinity
            2: v = {v[31], 8'hFF, v[22:0] | 23'd1};          // NaN
            3: v = {v[31], 8'h00, v[22:0]};                  // subnormal
            4: v = {v[31], 8'h7F, v[22:20], 20'd0};          // small set, many ties
            default: ;
        endcase
        return v;
    endfunction

    function automatic cmd_t mk(logic [1:0] op, logic [31:0] value);
        cmd_t c;
        c.op = op;
        c.value = value;
        return c;
    endfunction

    // Sorted run of n random values for one side.
    task automatic queue_run(logic [1:0] op, int n);
        logic [31:0] vals[$];
        logic [31:0] t;
        for (int i = 0; i < n; i++)
            vals.push_back(pick_float());
        // Insertion sort by the float order; NaNs land wherever they fall.
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && float_below(vals[j], vals[j-1]); j--)
            begin
                t = vals[j];
                vals[j] = vals[j-1];
                vals[j-1] = t;
            end
        foreach (vals[i])
            pending_cmds.push_back(mk(op, vals[i]));
    endtask

    // Source side: offers the head of the pending queue with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            // The accepted command leaves the queue here, so the next one is at its head.
            if (s_tvalid && s_tready)
            begin
                predict_merge(mk(s_tuser, s_tdata[31:0]));
                void'(pending_cmds.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_t nxt;
                    nxt = pending_cmds[0];
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {8'd0, nxt.value};
                    src_gap  <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random backpressure, plus a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end
        else if (hold_off > 0)
        begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (snk_gap > 0)
        begin
            m_tready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            snk_gap <= pick_gap();
        end
    end

    // Checker: every accepted element against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            merged_t got;
            merged_t exp_e;
            got.value = m_tdata;
            got.from_right = m_tuser[0];
            got.dropped = m_tuser[1];
            got.last = m_tlast;
            elems_seen++;
            if (got.last) merges_seen++;
            if (owed_elems.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected element %h fr=%b last=%b drop=%b",
                             got.value, got.from_right, got.last, got.dropped);
            end
            else
            begin
                exp_e = owed_elems.pop_front();
                if (got !== exp_e)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("element %0d: expected %h fr=%b last=%b drop=%b, got %h fr=%b last=%b drop=%b",
                                 elems_seen, exp_e.value, exp_e.from_right, exp_e.last,
                                 exp_e.dropped, got.value, got.from_right, got.last,
                                 got.dropped);
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("two_way_sorted_run_merge: mismatch");
            $finish;
        end
    end

    initial
    begin
        int n;
        errors = 0;
        merges_seen = 0;
        elems_seen = 0;
        cycles = 0;
        hold_off = 0;
        left_fill = 0;
        right_fill = 0;
        overflow_flag = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;

        // Directed part: empty merge, extremes, zeros of both signs, NaN, ties,
        // one run only, and the spare op code.
        pending_cmds.push_back(mk(OP_MERGE, 32'hFFFFFFFF));
        pending_cmds.push_back(mk(OP_LEFT, 32'h80000000));
        pending_cmds.push_back(mk(OP_LEFT, 32'h00000000));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h00000000));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h80000000));
        pending_cmds.push_back(mk(OP_SPARE, 32'h12345678));
        pending_cmds.push_back(mk(OP_MERGE, 32'h0));
        pending_cmds.push_back(mk(OP_LEFT, 32'hFF800000));
        pending_cmds.push_back(mk(OP_LEFT, 32'h7FC00000));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h3F800000));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h3F800000));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h7F800000));
        pending_cmds.push_back(mk(OP_MERGE, 32'h0));
        pending_cmds.push_back(mk(OP_LEFT, 32'hFFFFFFFF));
        pending_cmds.push_back(mk(OP_LEFT, 32'h00000001));
        pending_cmds.push_back(mk(OP_MERGE, 32'h0));
        pending_cmds.push_back(mk(OP_RIGHT, 32'h7F7FFFFF));
        pending_cmds.push_back(mk(OP_MERGE, 32'h0));
        pending_cmds.push_back(mk(OP_MERGE, 32'h0));

        // Random part: mostly sorted runs of random length, some noise, and a
        // few overfilled runs to set the dropped flag.
        n = 0;
        while (n < 230)
        begin
            int nl;
            int nr;
            case ($urandom_range(0, 9))
                0:
                begin
                    nl = DEPTH + $urandom_range(1, 3);
                    nr = $urandom_range(0, DEPTH);
                end
                1:
                begin
                    nl = $urandom_range(0, 4);
                    nr = DEPTH + $urandom_range(0, 2);
                end
                default:
                begin
                    nl = $urandom_range(0, 8);
                    nr = $urandom_range(0, 8);
                end
            endcase
            queue_run(OP_LEFT, nl);
            queue_run(OP_RIGHT, nr);
            if ($urandom_range(0, 4) == 0)
                pending_cmds.push_back(mk(2'($urandom_range(0, 3)), $urandom));
            pending_cmds.push_back(mk(OP_MERGE, $urandom));
            n += nl + nr + 1;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Once the block has some merges behind it, stall the receiver for a
        // long stretch while the source keeps offering.
        wait (merges_seen >= 4);
        @(posedge clk);
        hold_off <= 300;

        wait (pending_cmds.size() == 0 && !s_tvalid);
        wait (owed_elems.size() == 0);
        repeat (200) @(posedge clk);

        $display("Merged %0d runs, %0d elements checked, including zeros, NaNs, ties and overflow.",
                 merges_seen, elems_seen);
        if (errors == 0)
            $display("two_way_sorted_run_merge: match");
        else
            $display("two_way_sorted_run_merge: mismatch");
        $finish;
    end
endmodule
